@@ src/ltts_pkg.sv @@
// ----------------------------------------------------------------------------
// ltts_pkg
// Shared types and constants for the linear-to-tiled texture scatter block.
// ----------------------------------------------------------------------------
`default_nettype none

package ltts_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COORD_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int DIM_W    = 11;
  localparam int HALF_W   = 16;
  localparam int OFFSET_W = 22;
  localparam int REG_IDX_W = 2;

  localparam int TCOORD_W  = COORD_W - 2;
  localparam int TILES_X_W = $clog2(MAX_WIDTH / 4 + 1);
  localparam int TILES_Y_W = $clog2(MAX_HEIGHT / 4 + 1);
  localparam int TILE_W    = TCOORD_W + TILES_X_W;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PIXEL_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_RGBA8  = 1'b0,
    MODE_R5G6B5 = 1'b1
  } pixel_mode_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    pixel_mode_t      pixel_mode;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [HALF_W-1:0]   first_half;
    logic [HALF_W-1:0]   second_half;
    logic                second_valid;
    logic                dropped;
  } res_t;

endpackage

`default_nettype wire

@@ src/ltts_pixel_if.sv @@
// ----------------------------------------------------------------------------
// ltts_pixel_if
// Input pixel channel: valid/ready handshake with position and color.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltts_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [ltts_pkg::COORD_W-1:0]   pixel_x;
  logic [ltts_pkg::COORD_W-1:0]   pixel_y;
  logic [ltts_pkg::VALUE_W-1:0]   pixel_value;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_value,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input pixel_value,
                output ready);
endinterface

`default_nettype wire

@@ src/ltts_result_if.sv @@
// ----------------------------------------------------------------------------
// ltts_result_if
// Result channel: valid/ready handshake with the tiled write description.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltts_result_if;
  logic                            valid;
  logic                            ready;
  logic [ltts_pkg::OFFSET_W-1:0]   byte_offset;
  logic [ltts_pkg::HALF_W-1:0]     first_half;
  logic [ltts_pkg::HALF_W-1:0]     second_half;
  logic                            second_valid;
  logic                            dropped;

  modport source (output valid, output byte_offset, output first_half,
                  output second_half, output second_valid, output dropped,
                  input ready);
  modport sink (input valid, input byte_offset, input first_half,
                input second_half, input second_valid, input dropped,
                output ready);
endinterface

`default_nettype wire

@@ src/ltts_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ltts_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ltts_pkg::REG_IDX_W-1:0]   reg_index;
  logic [ltts_pkg::DIM_W-1:0]       data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

@@ src/ltts_map.sv @@
// ----------------------------------------------------------------------------
// ltts_map
// Maps one pixel position and color to its tile byte offset and halfwords.
// ----------------------------------------------------------------------------
`default_nettype none

module ltts_map (
  input  ltts_pkg::cfg_t                 cfg,
  input  logic [ltts_pkg::COORD_W-1:0]   pixel_x,
  input  logic [ltts_pkg::COORD_W-1:0]   pixel_y,
  input  logic [ltts_pkg::VALUE_W-1:0]   pixel_value,
  output ltts_pkg::res_t                 res
);
  import ltts_pkg::*;

  localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0]     width_eff;
  logic [DIM_W-1:0]     height_eff;
  logic [TILES_X_W-1:0] tiles_x;
  logic [TILES_Y_W-1:0] tiles_y;
  logic [TCOORD_W-1:0]  tile_col;
  logic [TCOORD_W-1:0]  tile_row;
  logic [3:0]           slot;
  logic [TILE_W-1:0]    tile;
  logic                 outside;

  always_comb begin
    width_eff  = (cfg.image_width > WIDTH_LIMIT) ? WIDTH_LIMIT : cfg.image_width;
    height_eff = (cfg.image_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg.image_height;
    tiles_x    = TILES_X_W'(width_eff >> 2);
    tiles_y    = TILES_Y_W'(height_eff >> 2);
    tile_col   = pixel_x[COORD_W-1:2];
    tile_row   = pixel_y[COORD_W-1:2];
    slot       = {pixel_y[1:0], pixel_x[1:0]};
    outside    = (TILE_W'(tile_col) >= TILE_W'(tiles_x)) ||
                 (TILE_W'(tile_row) >= TILE_W'(tiles_y));
    tile       = TILE_W'(TILE_W'(tile_row) * TILE_W'(tiles_x)) + TILE_W'(tile_col);

    res = '0;
    if (outside) begin
      res.dropped = 1'b1;
    end else begin
      case (cfg.pixel_mode)
        MODE_RGBA8: begin
          res.byte_offset  = OFFSET_W'({tile, 1'b0, slot, 1'b0});
          res.first_half   = {pixel_value[7:0], pixel_value[31:24]};
          res.second_half  = pixel_value[23:8];
          res.second_valid = 1'b1;
        end
        MODE_R5G6B5: begin
          res.byte_offset  = OFFSET_W'({tile, slot, 1'b0});
          res.first_half   = pixel_value[HALF_W-1:0];
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/linear_to_tiled_texture_scatter_top.sv @@
// ----------------------------------------------------------------------------
// linear_to_tiled_texture_scatter_top
// Scatters raster pixels into a 4x4-tiled texture layout. Each accepted pixel
// yields one result: the pixel is held in the input register, mapped through
// one 8x9 multiply and an add, and the result is held in an output register.
// The block takes one pixel every cycle while the result side keeps up; a
// stalled result holds the output register and the input register fills
// behind it before ready drops. Pixels outside the whole tiles of the
// configured width and height come out flagged as dropped with zero fields.
// Configuration writes are always taken and should only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_to_tiled_texture_scatter_top (
  input  logic          clk,
  input  logic          rst,
  ltts_cfg_if.sink      cfg,
  ltts_pixel_if.sink    pixel,
  ltts_result_if.source result
);
  import ltts_pkg::*;

  cfg_t                config_regs;
  logic                in_valid;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic [VALUE_W-1:0]  in_value;
  res_t                map_res;
  res_t                out_res;
  logic                out_valid;
  logic                out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      config_regs.image_width  <= RESET_WIDTH;
      config_regs.image_height <= RESET_HEIGHT;
      config_regs.pixel_mode   <= MODE_RGBA8;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_IMAGE_WIDTH:  config_regs.image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: config_regs.image_height <= cfg.data;
        REG_PIXEL_MODE:   config_regs.pixel_mode   <= pixel_mode_t'(cfg.data[0]);
        default: begin
        end
      endcase
    end
  end

  assign out_free    = !out_valid || result.ready;
  assign pixel.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel.ready) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      in_x     <= pixel.pixel_x;
      in_y     <= pixel.pixel_y;
      in_value <= pixel.pixel_value;
    end
  end

  ltts_map u_map (
    .cfg         (config_regs),
    .pixel_x     (in_x),
    .pixel_y     (in_y),
    .pixel_value (in_value),
    .res         (map_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= map_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.byte_offset  = out_res.byte_offset;
  assign result.first_half   = out_res.first_half;
  assign result.second_half  = out_res.second_half;
  assign result.second_valid = out_res.second_valid;
  assign result.dropped      = out_res.dropped;

endmodule

`default_nettype wire
